FILE: rtl/gtg_pkg.sv
package gtg_pkg;

  // vectoring steps of the angle/length unit
  localparam int CordicSteps = 16;
  // quotient bits produced by the distance divider
  localparam int DivSteps = 48;

  localparam logic signed [34:0] PiQ30     = 35'sd3373259426;
  localparam logic [30:0]        GainQ30   = 31'd1768195363;
  localparam logic [47:0]        DistClamp = 48'h8000_0000_0000;
  localparam logic [47:0]        DivQMax   = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [32:0] OneQ29    = 33'sh0_2000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_X     = 3'd0,
    REG_TARGET_Y     = 3'd1,
    REG_TARGET_ARMED = 3'd2,
    REG_STOP_RADIUS  = 3'd3,
    REG_LINEAR_GAIN  = 3'd4,
    REG_ANGULAR_GAIN = 3'd5
  } gtg_reg_t;

  // word handed from the front end to the back end
  typedef struct packed {
    logic signed [63:0] ux;
    logic signed [63:0] uy;
    logic [29:0]        mag;
    logic               sing;
  } gtg_work_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [30:0] atan_q30(input int idx);
    logic [30:0] v;
    case (idx)
      0:  v = 31'd843314856;
      1:  v = 31'd497837829;
      2:  v = 31'd263043836;
      3:  v = 31'd133525158;
      4:  v = 31'd67021686;
      5:  v = 31'd33543515;
      6:  v = 31'd16775850;
      7:  v = 31'd8388437;
      8:  v = 31'd4194282;
      9:  v = 31'd2097149;
      10: v = 31'd1048575;
      11: v = 31'd524287;
      12: v = 31'd262143;
      13: v = 31'd131071;
      14: v = 31'd65535;
      15: v = 31'd32767;
      16: v = 31'd16383;
      17: v = 31'd8191;
      18: v = 31'd4095;
      19: v = 31'd2047;
      20: v = 31'd1023;
      21: v = 31'd511;
      22: v = 31'd255;
      23: v = 31'd127;
      24: v = 31'd63;
      25: v = 31'd31;
      26: v = 31'd15;
      27: v = 31'd7;
      28: v = 31'd3;
      29: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/gtg_front.sv
module gtg_front
  import gtg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               armed,
  input  logic               stall,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               push,
  output gtg_work_t          word
);

  logic v1, v2, v3, v4, v5;
  logic signed [31:0] p_xx, p_yy, p_zz, p_xy, p_zw;
  logic signed [32:0] dx1, dy1, dx2, dy2;
  logic signed [32:0] r00, r01, r10, r11;
  logic signed [65:0] det_a, det_b, det;
  logic signed [65:0] det_s;
  logic signed [60:0] m11dx, m01dy, m00dy, m10dx;
  logic signed [61:0] ux4, uy4;
  logic signed [65:0] adet;
  logic               neg;

  // valid flags, only an armed word enters
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (!stall) begin
      v1 <= start && armed;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign push = v5 && !stall;
  assign det  = det_s;
  assign neg  = det[65];
  assign adet = neg ? -det : det;

  always_ff @(posedge clk) begin
    if (!stall) begin
      // quaternion products and world offset
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
      p_xy <= quat_x * quat_y;
      p_zw <= quat_z * quat_w;
      dx1  <= 33'(target_x) - 33'(robot_x);
      dy1  <= 33'(target_y) - 33'(robot_y);
      // rotation block in q.29
      r00 <= OneQ29 - (33'(p_yy) + 33'(p_zz));
      r11 <= OneQ29 - (33'(p_xx) + 33'(p_zz));
      r01 <= 33'(p_xy) - 33'(p_zw);
      r10 <= 33'(p_xy) + 33'(p_zw);
      dx2 <= dx1;
      dy2 <= dy1;
      // determinant and adjugate products
      det_a <= r00 * r11;
      det_b <= r01 * r10;
      m11dx <= $signed(r11[32:5]) * dx2;
      m01dy <= $signed(r01[32:5]) * dy2;
      m00dy <= $signed(r00[32:5]) * dy2;
      m10dx <= $signed(r10[32:5]) * dx2;
      // differences
      ux4 <= 62'(m11dx) - 62'(m01dy);
      uy4 <= 62'(m00dy) - 62'(m10dx);
      // sign fix and singularity class
      word.ux   <= neg ? -64'(ux4) : 64'(ux4);
      word.uy   <= neg ? -64'(uy4) : 64'(uy4);
      word.mag  <= adet[63:34];
      word.sing <= (adet[63:34] == 30'd0);
    end
  end

  // determinant difference stage (kept apart from the abs stage)
  always_ff @(posedge clk) begin
    if (!stall) begin
      det_s <= det_a - det_b;
    end
  end

endmodule

FILE: rtl/gtg_fifo.sv
module gtg_fifo
  import gtg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  gtg_work_t in_word,
  output logic      out_valid,
  output gtg_work_t out_word,
  output logic      full
);

  gtg_work_t  mem [0:1];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       pop;

  // the back end never stalls, so any held word drains at once
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid;
  assign full      = (count == 2'd2);
  assign out_word  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_word;
    end
  end

endmodule

FILE: rtl/gtg_cordic.sv
module gtg_cordic
  import gtg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  gtg_work_t          in_word,
  output logic               out_valid,
  output logic [62:0]        out_mag,
  output logic signed [34:0] out_ang,
  output logic [30:0]        out_denom,
  output logic               out_sing
);

  logic               sv    [0:CordicSteps];
  logic signed [63:0] sx    [0:CordicSteps];
  logic signed [63:0] sy    [0:CordicSteps];
  logic signed [34:0] sz    [0:CordicSteps];
  logic               szero [0:CordicSteps];
  logic               ssing [0:CordicSteps];
  logic [30:0]        sden  [1:CordicSteps];
  logic [60:0]        dprod;
  logic [30:0]        den0;

  // pre-rotation into the right half plane, scaled determinant product
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ux[63]) begin
      sx[0] <= -in_word.ux;
      sy[0] <= -in_word.uy;
      sz[0] <= in_word.uy[63] ? -PiQ30 : PiQ30;
    end else begin
      sx[0] <= in_word.ux;
      sy[0] <= in_word.uy;
      sz[0] <= '0;
    end
    szero[0] <= (in_word.ux == 64'sd0) && (in_word.uy == 64'sd0);
    ssing[0] <= in_word.sing;
    dprod    <= 61'(in_word.mag) * 61'(GainQ30);
  end

  assign den0 = (dprod[60:30] == 31'd0) ? 31'd1 : dprod[60:30];

  // one vectoring step per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [63:0] xs, ys;
    logic signed [34:0] at;
    assign xs = sx[i] >>> i;
    assign ys = sy[i] >>> i;
    assign at = $signed({4'b0, atan_q30(i)});

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else begin
        sv[i+1] <= sv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (sy[i][63]) begin
        sx[i+1] <= sx[i] - ys;
        sy[i+1] <= sy[i] + xs;
        sz[i+1] <= sz[i] - at;
      end else begin
        sx[i+1] <= sx[i] + ys;
        sy[i+1] <= sy[i] - xs;
        sz[i+1] <= sz[i] + at;
      end
      szero[i+1] <= szero[i];
      ssing[i+1] <= ssing[i];
    end

    if (i == 0) begin : g_den_first
      always_ff @(posedge clk) begin
        sden[i+1] <= den0;
      end
    end else begin : g_den_carry
      always_ff @(posedge clk) begin
        sden[i+1] <= sden[i];
      end
    end
  end

  assign out_valid = sv[CordicSteps];
  assign out_mag   = sx[CordicSteps][63] ? 63'd0 : sx[CordicSteps][62:0];
  assign out_ang   = szero[CordicSteps] ? 35'sd0 : sz[CordicSteps];
  assign out_denom = sden[CordicSteps];
  assign out_sing  = ssing[CordicSteps];

endmodule

FILE: rtl/gtg_div.sv
module gtg_div
  import gtg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [62:0]        num,
  input  logic [30:0]        den,
  input  logic signed [34:0] in_ang,
  input  logic               in_sing,
  output logic               out_valid,
  output logic [47:0]        quo,
  output logic               ovf,
  output logic signed [34:0] out_ang,
  output logic               out_sing
);

  logic               dv   [0:DivSteps];
  logic [30:0]        drem [0:DivSteps];
  logic [47:0]        dn   [0:DivSteps];
  logic [47:0]        dq   [0:DivSteps];
  logic               dovf [0:DivSteps];
  logic [30:0]        dden [0:DivSteps];
  logic signed [34:0] dang [0:DivSteps];
  logic               dsng [0:DivSteps];

  // top bits first: a quotient of 2^48 or more only needs flagging
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    drem[0] <= {16'd0, num[62:48]};
    dn[0]   <= num[47:0];
    dq[0]   <= '0;
    dovf[0] <= ({16'd0, num[62:48]} >= den);
    dden[0] <= den;
    dang[0] <= in_ang;
    dsng[0] <= in_sing;
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DivSteps; k++) begin : g_bit
    logic [31:0] t, diff;
    logic        ge;
    assign t    = {drem[k], dn[k][47]};
    assign ge   = (t >= {1'b0, dden[k]});
    assign diff = t - {1'b0, dden[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      drem[k+1] <= ge ? diff[30:0] : t[30:0];
      dn[k+1]   <= {dn[k][46:0], 1'b0};
      dq[k+1]   <= {dq[k][46:0], ge};
      dovf[k+1] <= dovf[k];
      dden[k+1] <= dden[k];
      dang[k+1] <= dang[k];
      dsng[k+1] <= dsng[k];
    end
  end

  assign out_valid = dv[DivSteps];
  assign quo       = dovf[DivSteps] ? DivQMax : dq[DivSteps];
  assign ovf       = dovf[DivSteps];
  assign out_ang   = dang[DivSteps];
  assign out_sing  = dsng[DivSteps];

endmodule

FILE: rtl/goto_goal_velocity_controller.sv
// path: front end, two-entry queue, angle/length unit, distance divider, output registers
//   (the vectoring unit has 16 steps)
// throughput: one pose per cycle while busy is low; the front end, angle unit and the
//   48-stage distance divider are fully pipelined
// reset: synchronous, clears configuration to defaults and all valid flags
// results are strobed on done for one cycle and cannot be held off
module goto_goal_velocity_controller
  import gtg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               done,
  output logic signed [31:0] linear_speed,
  output logic signed [31:0] turn_rate
);

  logic signed [31:0] target_x, target_y;
  logic               target_armed;
  logic [30:0]        stop_radius;
  logic [15:0]        linear_gain, angular_gain;

  gtg_work_t          f_word, q_word;
  logic               q_push, q_full, q_valid;
  logic               c_valid, c_sing;
  logic [62:0]        c_mag;
  logic signed [34:0] c_ang;
  logic [30:0]        c_denom;
  logic               d_valid, d_ovf, d_sing;
  logic [47:0]        d_quo;
  logic signed [34:0] d_ang;

  logic               fv1, fv2;
  logic [47:0]        fdist;
  logic signed [34:0] fang;
  logic               fsing1, fsing2;
  logic [63:0]        lin_prod;
  logic signed [51:0] turn_prod;
  logic [47:0]        dist_c;
  logic [51:0]        lin_sh;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_x     <= '0;
      target_y     <= '0;
      target_armed <= 1'b0;
      stop_radius  <= 31'd85197;
      linear_gain  <= 16'd3686;
      angular_gain <= 16'd4506;
    end else if (wr_en) begin
      unique case (gtg_reg_t'(wr_index))
        REG_TARGET_X:     target_x     <= wr_data;
        REG_TARGET_Y:     target_y     <= wr_data;
        REG_TARGET_ARMED: target_armed <= wr_data[0];
        REG_STOP_RADIUS:  stop_radius  <= wr_data[30:0];
        REG_LINEAR_GAIN:  linear_gain  <= wr_data[15:0];
        REG_ANGULAR_GAIN: angular_gain <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = q_full;

  gtg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .armed    (target_armed),
    .stall    (q_full),
    .target_x (target_x),
    .target_y (target_y),
    .robot_x  (robot_x),
    .robot_y  (robot_y),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .push     (q_push),
    .word     (f_word)
  );

  gtg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .in_word   (f_word),
    .out_valid (q_valid),
    .out_word  (q_word),
    .full      (q_full)
  );

  gtg_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_word   (q_word),
    .out_valid (c_valid),
    .out_mag   (c_mag),
    .out_ang   (c_ang),
    .out_denom (c_denom),
    .out_sing  (c_sing)
  );

  gtg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .num       (c_mag),
    .den       (c_denom),
    .in_ang    (c_ang),
    .in_sing   (c_sing),
    .out_valid (d_valid),
    .quo       (d_quo),
    .ovf       (d_ovf),
    .out_ang   (d_ang),
    .out_sing  (d_sing)
  );

  // clamp distance and apply the stop radius
  assign dist_c = (d_ovf || (d_quo > DistClamp)) ? DistClamp : d_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv1  <= 1'b0;
      fv2  <= 1'b0;
      done <= 1'b0;
    end else begin
      fv1  <= d_valid;
      fv2  <= fv1;
      done <= fv2;
    end
  end

  always_ff @(posedge clk) begin
    fdist  <= (dist_c <= {17'd0, stop_radius}) ? 48'd0 : dist_c;
    fang   <= d_ang;
    fsing1 <= d_sing;
    // gain products
    lin_prod  <= 64'(fdist) * 64'(linear_gain);
    turn_prod <= fang * $signed({1'b0, angular_gain});
    fsing2    <= fsing1;
  end

  assign lin_sh = lin_prod[63:12];

  // scale, saturate and drive the result word
  always_ff @(posedge clk) begin
    if (fsing2) begin
      linear_speed <= '0;
      turn_rate    <= '0;
    end else begin
      linear_speed <= (lin_sh[51:31] != 21'd0) ? 32'sh7FFF_FFFF
                                               : $signed({1'b0, lin_sh[30:0]});
      // the scaled angle always fits, no clipping needed
      turn_rate    <= 32'($signed(turn_prod[51:26]));
    end
  end

  // speed command is never negative
  a_lin_nonneg: assert property (@(posedge clk) disable iff (rst)
    done |-> !linear_speed[31])
    else $error("negative linear speed");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result after reset");

  // queue is never written while full
  a_queue_safe: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue overflow");

endmodule
